// ===== rtl/core/blm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blm_pkg
// Types and constants shared by the battery level monitor modules.
// ============================================================================
package blm_pkg;

    localparam int unsigned SUM_W   = 20;
    localparam int unsigned DIV_W   = 33;
    localparam int unsigned DSR_W   = 16;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned NUM_W   = 23;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [6:0] PCT_SCALE = 7'd100;

    localparam logic [STEP_W-1:0] STEPS_SCL = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] STEPS_PCT = STEP_W'(NUM_W);

    typedef enum logic [CIDX_W-1:0] {
        CFG_VREF_MV    = 3'd0,
        CFG_FULL_SCALE = 3'd1,
        CFG_DIV_RATIO  = 3'd2,
        CFG_FULL_MV    = 3'd3,
        CFG_EMPTY_MV   = 3'd4,
        CFG_LOW_THR    = 3'd5,
        CFG_HYST       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] adc_sample;
        logic        sample_ok;
    } t_in;

    typedef struct packed {
        logic [15:0] battery_mv;
        logic [6:0]  charge_pct;
        logic        battery_low;
    } t_out;

    typedef struct packed {
        logic [12:0] vref_mv;
        logic [15:0] adc_full_scale;
        logic [3:0]  divider_ratio;
        logic [15:0] full_mv;
        logic [15:0] empty_mv;
        logic [6:0]  low_threshold_pct;
        logic [6:0]  hysteresis_pct;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/battery_level_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// battery_level_monitor
// Battery voltage gauge with percent and a low flag with hysteresis.
// ============================================================================
// Usage:
//   Input queue side: drive i_in and raise push; the sample transaction is
//   taken on a clock edge with push high and full low. Every
//   SAMPLES_PER_READING samples close one batch; the batch sum enters a
//   two-entry queue, so samples are taken one per cycle while it has room.
//   Result queue side: while empty is low, o_out holds the oldest reading;
//   raise pop to take it. One result per batch, none for other samples.
//   Configuration: write register i_cfg_idx with i_cfg_data while i_cfg_we
//   is high; only while no batch is in flight. Unknown indexes are ignored.
//   Sequence: once a batch's last sample is taken, its sum is queued; the
//   sequencer averages it by reciprocal multiply, multiplies by vref, makes
//   two passes through the shared one-bit-per-cycle divider (full scale,
//   then percent) around the divider ratio and clamp, and queues the result.
//   Overlap: the sequencer takes the next waiting sum only after it has
//   queued the previous reading. A pass whose divisor is not positive is skipped.
//   Reset: registers return to defaults, sum, count and low flag clear, and
//   both queues empty. No clearing pass is needed.
//   Stall: if pop is held off, results wait in a two-entry queue, the
//   sequencer holds its finished reading, batches back up, and full rises.
// ============================================================================
module battery_level_monitor #(
    parameter int unsigned SAMPLES_PER_READING = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  blm_pkg::t_in               i_in,
    output logic                       empty,
    input  logic                       pop,
    output blm_pkg::t_out              o_out,
    input  logic                       i_cfg_we,
    input  logic [blm_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [blm_pkg::CFG_W-1:0]  i_cfg_data
);
    import blm_pkg::*;

    localparam int unsigned OUT_W = $bits(t_out);

    t_cfg             r_cfg;
    logic             in_accept;
    logic             batch_push;
    logic [SUM_W-1:0] batch_sum;
    logic             sum_empty;
    logic [SUM_W-1:0] sum_head;
    logic             sum_pop;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             out_full;
    logic             out_push;
    t_out             out_item;
    logic [OUT_W-1:0] out_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vref_mv           <= 13'd3300;
            r_cfg.adc_full_scale    <= 16'd4095;
            r_cfg.divider_ratio     <= 4'd2;
            r_cfg.full_mv           <= 16'd4200;
            r_cfg.empty_mv          <= 16'd3000;
            r_cfg.low_threshold_pct <= 7'd20;
            r_cfg.hysteresis_pct    <= 7'd5;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_VREF_MV:    r_cfg.vref_mv           <= i_cfg_data[12:0];
                CFG_FULL_SCALE: r_cfg.adc_full_scale    <= i_cfg_data;
                CFG_DIV_RATIO:  r_cfg.divider_ratio     <= i_cfg_data[3:0];
                CFG_FULL_MV:    r_cfg.full_mv           <= i_cfg_data;
                CFG_EMPTY_MV:   r_cfg.empty_mv          <= i_cfg_data;
                CFG_LOW_THR:    r_cfg.low_threshold_pct <= i_cfg_data[6:0];
                CFG_HYST:       r_cfg.hysteresis_pct    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign in_accept = push && !full;

    blm_front #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_in    (i_in),
        .o_push  (batch_push),
        .o_sum   (batch_sum)
    );

    blm_fifo #(
        .WIDTH(SUM_W),
        .DEPTH(2)
    ) u_sum_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (batch_push),
        .i_data (batch_sum),
        .o_full (full),
        .i_pop  (sum_pop),
        .o_data (sum_head),
        .o_empty(sum_empty)
    );

    blm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    blm_back #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_sum_empty(sum_empty),
        .i_sum      (sum_head),
        .o_sum_pop  (sum_pop),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out      (out_item)
    );

    blm_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(2)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_item),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (out_head),
        .o_empty(empty)
    );

    assign o_out = t_out'(out_head);

endmodule

// ===== rtl/core/blm_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blm_fifo
// Small register-based queue with push/full and pop/empty sides.
// ============================================================================
module blm_fifo #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/blm_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blm_front
// Sample accumulator: sums accepted samples and hands off each full batch.
// ============================================================================
module blm_front #(
    parameter int unsigned SAMPLES_PER_READING = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  blm_pkg::t_in                i_in,
    output logic                        o_push,
    output logic [blm_pkg::SUM_W-1:0]   o_sum
);
    import blm_pkg::*;

    localparam int unsigned CNT_W =
        (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             last;

    assign n_sum  = r_sum + (i_in.sample_ok ? SUM_W'(i_in.adc_sample) : '0);
    assign last   = (r_cnt == CNT_LAST);
    assign o_push = i_accept && last;
    assign o_sum  = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            if (last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/blm_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blm_div
// Shared restoring divider, one quotient bit per cycle over the top bits.
// ============================================================================
module blm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blm_pkg::t_div_req i_req,
    output blm_pkg::t_div_rsp o_rsp
);
    import blm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    diff;
    logic              ge;

    assign shifted = {r_rem, r_dvd[DIV_W-1]};
    assign diff    = shifted - {1'b0, r_dsr};
    assign ge      = (shifted >= {1'b0, r_dsr});

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
`endif

endmodule

// ===== rtl/core/blm_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// blm_back
// Reading sequencer: average, scale to millivolts, percent and low flag.
// ============================================================================
module blm_back #(
    parameter int unsigned SAMPLES_PER_READING = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  blm_pkg::t_cfg             i_cfg,
    input  logic                      i_sum_empty,
    input  logic [blm_pkg::SUM_W-1:0] i_sum,
    output logic                      o_sum_pop,
    output blm_pkg::t_div_req         o_div_req,
    input  blm_pkg::t_div_rsp         i_div_rsp,
    input  logic                      i_out_full,
    output logic                      o_out_push,
    output blm_pkg::t_out             o_out
);
    import blm_pkg::*;

    localparam int unsigned AVG_L  = $clog2(SAMPLES_PER_READING);
    localparam int unsigned AVG_SH = SUM_W + AVG_L;
    localparam int unsigned RCP_W  = SUM_W + 1;
    localparam int unsigned AVG_PW = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_SH) + 64'(SAMPLES_PER_READING) - 64'd1)
               / 64'(SAMPLES_PER_READING));

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_AVG      = 10'b00_0000_0010,
        S_MUL      = 10'b00_0000_0100,
        S_SCL      = 10'b00_0000_1000,
        S_SCL_WAIT = 10'b00_0001_0000,
        S_MV       = 10'b00_0010_0000,
        S_CLAMP    = 10'b00_0100_0000,
        S_PCT      = 10'b00_1000_0000,
        S_PCT_WAIT = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [SUM_W-1:0]  r_raw,   n_raw;
    logic [DIV_W-1:0]  r_prod,  n_prod;
    logic [15:0]       r_adc,   n_adc;
    logic [15:0]       r_mv,    n_mv;
    logic [NUM_W-1:0]  r_num,   n_num;
    logic [6:0]        r_pct,   n_pct;
    logic              r_low,   n_low;
    logic [AVG_PW-1:0] avg_prod;
    logic [19:0]       mv_prod;
    logic [15:0]       v_hi;
    logic [15:0]       v_clip;
    logic [7:0]        thr_hi;
    logic              flag_next;

    assign avg_prod = AVG_PW'(r_raw) * AVG_PW'(AVG_RCP);
    assign mv_prod  = 20'(r_adc) * 20'(i_cfg.divider_ratio);
    assign v_hi     = (r_mv > i_cfg.full_mv) ? i_cfg.full_mv : r_mv;
    assign v_clip   = (v_hi < i_cfg.empty_mv) ? i_cfg.empty_mv : v_hi;
    assign thr_hi   = 8'(i_cfg.low_threshold_pct) + 8'(i_cfg.hysteresis_pct);

    always_comb begin
        if (r_pct <= i_cfg.low_threshold_pct) begin
            flag_next = 1'b1;
        end else if (8'(r_pct) >= thr_hi) begin
            flag_next = 1'b0;
        end else begin
            flag_next = r_low;
        end
    end

    assign o_out.battery_mv  = r_mv;
    assign o_out.charge_pct  = r_pct;
    assign o_out.battery_low = flag_next;

    always_comb begin
        n_state    = r_state;
        n_raw      = r_raw;
        n_prod     = r_prod;
        n_adc      = r_adc;
        n_mv       = r_mv;
        n_num      = r_num;
        n_pct      = r_pct;
        n_low      = r_low;
        o_sum_pop  = 1'b0;
        o_out_push = 1'b0;
        o_div_req  = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_sum_empty) begin
                    o_sum_pop = 1'b1;
                    n_raw     = i_sum;
                    n_state   = S_AVG;
                end
            end
            S_AVG: begin
                n_raw   = SUM_W'(avg_prod >> AVG_SH);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = DIV_W'(r_raw) * DIV_W'(i_cfg.vref_mv);
                n_state = S_SCL;
            end
            S_SCL: begin
                if (i_cfg.adc_full_scale == '0) begin
                    n_adc   = '0;
                    n_state = S_MV;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_prod;
                    o_div_req.divisor  = i_cfg.adc_full_scale;
                    o_div_req.steps    = STEPS_SCL;
                    n_state            = S_SCL_WAIT;
                end
            end
            S_SCL_WAIT: begin
                if (i_div_rsp.done) begin
                    n_adc   = i_div_rsp.quotient[15:0];
                    n_state = S_MV;
                end
            end
            S_MV: begin
                n_mv    = mv_prod[15:0];
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_num   = NUM_W'(v_clip - i_cfg.empty_mv) * NUM_W'(PCT_SCALE);
                n_state = S_PCT;
            end
            S_PCT: begin
                if (i_cfg.full_mv > i_cfg.empty_mv) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {r_num, (DIV_W - NUM_W)'(0)};
                    o_div_req.divisor  = i_cfg.full_mv - i_cfg.empty_mv;
                    o_div_req.steps    = STEPS_PCT;
                    n_state            = S_PCT_WAIT;
                end else begin
                    n_pct   = '0;
                    n_state = S_EMIT;
                end
            end
            S_PCT_WAIT: begin
                if (i_div_rsp.done) begin
                    n_pct   = i_div_rsp.quotient[6:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_low      = flag_next;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_prod <= n_prod;
        r_adc  <= n_adc;
        r_mv   <= n_mv;
        r_num  <= n_num;
        r_pct  <= n_pct;
    end

`ifndef SYNTH
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divide started while divider busy");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into full queue");
    a_pct_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (o_out.charge_pct <= PCT_SCALE))
        else $error("charge percent above full scale");
`endif

endmodule
